### rtl/core/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JSUE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define JSUE_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define JSUE_ASSERT(label, clk, rst, prop)
`define JSUE_NEVER(label, clk, rst, cond)
`endif
`endif

### rtl/core/jsue_pkg.sv
// shared types and constants of the json string escaper
package jsue_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_LOW_D  = 8'h64;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   typedef enum logic [2:0] {
      BODY_NONE  = 3'd0,
      BODY_RAW   = 3'd1,
      BODY_ESC2  = 3'd2,
      BODY_U00   = 3'd3,
      BODY_FFFD  = 3'd4,
      BODY_CLOSE = 3'd5
   } body_kind_type;

   typedef struct packed {
      logic              open_quote;
      logic [1:0]        fffd_count;
      body_kind_type     body;
      logic [2:0]        raw_count;
      logic [3:0][7:0]   raw;
   } cmd_type;

   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

endpackage

### rtl/core/jsue_front.sv
// front end: accepts bytes, tracks utf-8 state and issues output commands
module jsue_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // data_byte
   input  logic                      req_tuser,   // kind
   input  jsue_pkg::queue_status_type q_status,
   output logic                      push,
   output jsue_pkg::cmd_type         push_cmd
);
   import jsue_pkg::*;

   logic [7:0] pend_bytes_ff [3];
   logic [7:0] pend_bytes_in [3];
   logic [1:0] pend_count_ff, pend_count_in;
   logic [2:0] seq_len_ff, seq_len_in;
   logic       quote_open_ff, quote_open_in;

   logic       accept;
   logic       fresh_en;
   logic [2:0] lead_len;
   logic       cont_ok;
   logic [7:0] b;
   cmd_type    cmd;

   function automatic logic [2:0] lead_length(input logic [7:0] v);
      logic [2:0] len;
      len = 3'd0;
      if (v >= 8'hc2 && v <= 8'hdf) len = 3'd2;
      else if (v >= 8'he0 && v <= 8'hef) len = 3'd3;
      else if (v >= 8'hf0 && v <= 8'hf4) len = 3'd4;
      return len;
   endfunction

   function automatic logic continuation(input logic [7:0] lead, input logic [1:0] pos,
                                         input logic [7:0] v);
      logic ok;
      ok = (v >= 8'h80) && (v <= 8'hbf);
      if (pos == 2'd1) begin
         if (lead == 8'he0 && v < 8'ha0) ok = 1'b0;
         if (lead == 8'hed && v >= 8'ha0) ok = 1'b0;
         if (lead == 8'hf0 && v < 8'h90) ok = 1'b0;
         if (lead == 8'hf4 && v > 8'h8f) ok = 1'b0;
      end
      return ok;
   endfunction

   assign b          = req_tdata;
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign lead_len   = lead_length(b);
   assign cont_ok    = continuation(pend_bytes_ff[0], pend_count_ff, b);

   always_comb begin
      cmd            = '0;
      cmd.open_quote = !quote_open_ff;
      cmd.body       = BODY_NONE;
      cmd.raw_count  = 3'd1;
      cmd.raw[0]     = b;
      fresh_en       = 1'b0;
      pend_bytes_in  = pend_bytes_ff;
      pend_count_in  = pend_count_ff;
      seq_len_in     = seq_len_ff;
      quote_open_in  = quote_open_ff;
      if (req_tuser) begin
         cmd.fffd_count = pend_count_ff;
         cmd.body       = BODY_CLOSE;
         pend_count_in  = 2'd0;
         seq_len_in     = 3'd0;
         quote_open_in  = 1'b0;
      end else begin
         quote_open_in = 1'b1;
         if (pend_count_ff == 2'd0) begin
            fresh_en = 1'b1;
         end else if (cont_ok) begin
            if (({1'b0, pend_count_ff} + 3'd1) >= seq_len_ff) begin
               cmd.body      = BODY_RAW;
               cmd.raw_count = {1'b0, pend_count_ff} + 3'd1;
               for (int i = 0; i < 3; i++) begin
                  cmd.raw[i] = (2'(i) < pend_count_ff) ? pend_bytes_ff[i] : b;
               end
               cmd.raw[3]    = b;
               pend_count_in = 2'd0;
               seq_len_in    = 3'd0;
            end else begin
               pend_bytes_in[pend_count_ff] = b;
               pend_count_in = pend_count_ff + 2'd1;
            end
         end else begin
            cmd.fffd_count = pend_count_ff;
            pend_count_in  = 2'd0;
            seq_len_in     = 3'd0;
            fresh_en       = 1'b1;
         end
         if (fresh_en) begin
            priority if (b == CH_QUOTE || b == CH_BSLASH) begin
               cmd.body = BODY_ESC2;
            end else if (b == 8'h08) begin
               cmd.body   = BODY_ESC2;
               cmd.raw[0] = CH_LOW_B;
            end else if (b == 8'h0c) begin
               cmd.body   = BODY_ESC2;
               cmd.raw[0] = CH_LOW_F;
            end else if (b == 8'h0a) begin
               cmd.body   = BODY_ESC2;
               cmd.raw[0] = CH_LOW_N;
            end else if (b == 8'h0d) begin
               cmd.body   = BODY_ESC2;
               cmd.raw[0] = CH_LOW_R;
            end else if (b == 8'h09) begin
               cmd.body   = BODY_ESC2;
               cmd.raw[0] = CH_LOW_T;
            end else if (b < 8'h20) begin
               cmd.body = BODY_U00;
            end else if (b < 8'h80) begin
               cmd.body = BODY_RAW;
            end else if (lead_len == 3'd0) begin
               cmd.body = BODY_FFFD;
            end else begin
               pend_bytes_in[0] = b;
               pend_count_in    = 2'd1;
               seq_len_in       = lead_len;
            end
         end
      end
   end

   assign push     = accept && (cmd.open_quote || cmd.fffd_count != 2'd0 ||
                                cmd.body != BODY_NONE);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_count_ff <= 2'd0;
         seq_len_ff    <= 3'd0;
         quote_open_ff <= 1'b0;
      end else if (accept) begin
         pend_count_ff <= pend_count_in;
         seq_len_ff    <= seq_len_in;
         quote_open_ff <= quote_open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_bytes_ff <= pend_bytes_in;
      end
   end

endmodule

### rtl/core/jsue_queue.sv
// command queue between front and back end
module jsue_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  jsue_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output jsue_pkg::cmd_type          head_cmd,
   output jsue_pkg::queue_status_type status
);
   import jsue_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/jsue_back.sv
// back end: expands commands into output bytes behind an output register
module jsue_back (
   input  logic              clock,
   input  logic              reset,
   input  jsue_pkg::cmd_type head_cmd,
   input  logic              head_valid,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // out_byte
   output logic              rsp_tlast    // last_of_run
);
   import jsue_pkg::*;

   typedef enum logic [2:0] {
      PH_QUOTE = 3'b001,
      PH_FLUSH = 3'b010,
      PH_BODY  = 3'b100
   } phase_type;

   localparam logic [2:0] SUB_LAST6 = 3'd5;

   phase_type  phase_ff, phase_in, cur_phase;
   logic       busy_ff, busy_in;
   logic [2:0] sub_ff, sub_in, cur_sub;
   logic [1:0] left_ff, left_in, cur_left;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_tdata_ff, rsp_tdata_in;
   logic       rsp_tlast_ff, rsp_tlast_in;
   logic [7:0] byte_c;
   logic [2:0] body_len;
   logic       last_c;
   logic       load_en, step;

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (CH_ZERO + {4'd0, n}) : (8'h57 + {4'd0, n});
   endfunction

   function automatic logic [7:0] fffd_char(input logic [2:0] s);
      logic [7:0] c;
      unique case (s)
         3'd0:    c = CH_BSLASH;
         3'd1:    c = CH_LOW_U;
         3'd5:    c = CH_LOW_D;
         default: c = CH_LOW_F;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] u00_char(input logic [2:0] s, input logic [7:0] v);
      logic [7:0] c;
      unique case (s)
         3'd0:    c = CH_BSLASH;
         3'd1:    c = CH_LOW_U;
         3'd4:    c = hex_char(v[7:4]);
         3'd5:    c = hex_char(v[3:0]);
         default: c = CH_ZERO;
      endcase
      return c;
   endfunction

   always_comb begin
      unique case (head_cmd.body)
         BODY_RAW:   body_len = head_cmd.raw_count;
         BODY_ESC2:  body_len = 3'd2;
         BODY_U00:   body_len = 3'd6;
         BODY_FFFD:  body_len = 3'd6;
         BODY_CLOSE: body_len = 3'd1;
         default:    body_len = 3'd0;
      endcase
   end

   always_comb begin
      if (busy_ff) begin
         cur_phase = phase_ff;
         cur_sub   = sub_ff;
         cur_left  = left_ff;
      end else begin
         cur_sub  = 3'd0;
         cur_left = head_cmd.fffd_count;
         if (head_cmd.open_quote) cur_phase = PH_QUOTE;
         else if (head_cmd.fffd_count != 2'd0) cur_phase = PH_FLUSH;
         else cur_phase = PH_BODY;
      end
   end

   always_comb begin
      byte_c   = '0;
      last_c   = 1'b0;
      phase_in = cur_phase;
      sub_in   = cur_sub + 3'd1;
      left_in  = cur_left;
      unique case (cur_phase)
         PH_QUOTE: begin
            byte_c = CH_QUOTE;
            sub_in = 3'd0;
            if (head_cmd.fffd_count != 2'd0) begin
               phase_in = PH_FLUSH;
               left_in  = head_cmd.fffd_count;
            end else if (head_cmd.body != BODY_NONE) begin
               phase_in = PH_BODY;
            end else begin
               last_c = 1'b1;
            end
         end
         PH_FLUSH: begin
            byte_c = fffd_char(cur_sub);
            if (cur_sub == SUB_LAST6) begin
               sub_in  = 3'd0;
               left_in = cur_left - 2'd1;
               if (cur_left > 2'd1) begin
                  phase_in = PH_FLUSH;
               end else if (head_cmd.body != BODY_NONE) begin
                  phase_in = PH_BODY;
               end else begin
                  last_c = 1'b1;
               end
            end
         end
         PH_BODY: begin
            unique case (head_cmd.body)
               BODY_RAW:   byte_c = head_cmd.raw[cur_sub[1:0]];
               BODY_ESC2:  byte_c = (cur_sub == 3'd0) ? CH_BSLASH : head_cmd.raw[0];
               BODY_U00:   byte_c = u00_char(cur_sub, head_cmd.raw[0]);
               BODY_FFFD:  byte_c = fffd_char(cur_sub);
               BODY_CLOSE: byte_c = CH_QUOTE;
               default:    byte_c = '0;
            endcase
            if (cur_sub == body_len - 3'd1) last_c = 1'b1;
         end
         default: begin
            last_c = 1'b1;
         end
      endcase
   end

   assign load_en = !rsp_tvalid_ff || rsp_tready;
   assign step    = head_valid && load_en;
   assign pop     = step && last_c;
   assign busy_in = !last_c;

   always_comb begin
      rsp_tvalid_in = head_valid;
      rsp_tdata_in  = byte_c;
      rsp_tlast_in  = last_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         phase_ff      <= PH_QUOTE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (step) begin
            busy_ff  <= busy_in;
            phase_ff <= phase_in;
         end
         if (load_en) rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         sub_ff       <= sub_in;
         left_ff      <= left_in;
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tlast_ff <= rsp_tlast_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

### rtl/core/json_string_escape_utf8_check_unit.sv
// top level of the json string escaper with utf-8 checking
//
//   channel  direction  tdata            tuser       tlast
//   req_     in         [7:0] data_byte  kind        -
//   rsp_     out        [7:0] out_byte   -           last_of_run
//
// one input transaction per cycle while the command queue has room
// one output byte per cycle from the expander while the output is not
// stalled; escapes and flushes emit up to 24 bytes for one input
// the four-entry command queue lets the front keep accepting while the
// expander works or the output stalls
// synchronous reset clears utf-8 state, queue pointers and output valid

`include "assert_macros.svh"

module json_string_escape_utf8_check_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tuser,   // kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast    // last_of_run
);
   import jsue_pkg::*;

   logic             push, pop;
   cmd_type          push_cmd, head_cmd;
   queue_status_type q_status;

   jsue_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   jsue_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   jsue_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (!q_status.empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `JSUE_NEVER(a_pop_empty, clock, reset, pop && q_status.empty)
   `JSUE_ASSERT(a_pop_last, clock, reset, pop |=> (rsp_tvalid && rsp_tlast))
   `JSUE_ASSERT(a_idle_quiet, clock, reset, (!rsp_tvalid && q_status.empty) |=> !rsp_tvalid)

endmodule
